// ----- rtl/lscc_pkg.sv -----
`default_nettype none

package lscc_pkg;

   localparam int SAMPLE_W = 12;
   localparam int CALIB_W = 2 * SAMPLE_W;
   localparam int CALIB_REGS = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int SENSOR_IDX_W = 3;
   localparam int LINE_W = 8;
   localparam int DEFAULT_SENSOR_COUNT = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int COUNT_W = 4;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};
   // ceil(2^16 / 3): exact floor(x / 3) for every x below 2^15
   localparam logic [15:0] RECIP3 = 16'd21846;

   localparam logic [CALIB_W-1:0] CALIB_RESET [CALIB_REGS] = '{
      24'h42302C, 24'h4AC035, 24'h4D3034, 24'h4DD048,
      24'h4B5038, 24'h43C043, 24'h4F906D, 24'h49903D
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_THRESH,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } lscc_state_type;

   typedef struct packed {
      logic load;
      logic thresh;
      logic update;
      logic div_step;
      logic out_load;
   } lscc_cmd_type;

   typedef struct packed {
      logic out_free;
   } lscc_status_type;

endpackage

`default_nettype wire

// ----- rtl/lscc_ctrl.sv -----
`default_nettype none

module lscc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  lscc_pkg::lscc_status_type status,
   output lscc_pkg::lscc_cmd_type  cmd
);
   import lscc_pkg::*;

   lscc_state_type state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_THRESH;
         end
         ST_THRESH: state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = ST_DIVIDE;
            count_in = '0;
         end
         ST_DIVIDE: begin
            count_in = count_ff + 1'b1;
            if (count_ff == COUNT_W'(SAMPLE_W - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         ST_THRESH: cmd.thresh = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_FINISH: cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/lscc_datapath.sv -----
`default_nettype none

module lscc_datapath #(
   parameter int SENSOR_COUNT = lscc_pkg::DEFAULT_SENSOR_COUNT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  lscc_pkg::lscc_cmd_type              cmd,
   output lscc_pkg::lscc_status_type           status,
   input  wire  [lscc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [lscc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire                                 csr_we,
   input  wire  [lscc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [lscc_pkg::CALIB_W-1:0]        csr_wdata
);
   import lscc_pkg::*;

   logic [CALIB_W-1:0] calib_ff [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] line_ff, line_in;

   logic [SENSOR_IDX_W-1:0] idx_ff, idx_in;
   logic in_range_ff, in_range_in;
   logic [SAMPLE_W-1:0] s_ff, w_ff, b_ff, w_in, b_in;
   logic [SAMPLE_W-1:0] upper_ff, lower_ff;
   logic [CALIB_W-1:0] num_ff;
   logic [SAMPLE_W-1:0] den_ff;
   logic zero_ff;
   logic [SAMPLE_W-1:0] rem_ff, rem_in, num_lo_ff, quot_ff;
   logic sat_ff;
   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [2:0] req_mux;
   logic [SAMPLE_W-1:0] req_sample;
   logic [CALIB_W-1:0] word;
   logic [SAMPLE_W-1:0] word_w, word_b;
   logic [SAMPLE_W+1:0] sum_u, sum_l;
   logic [29:0] prod_u, prod_l;
   logic [SAMPLE_W-1:0] diff;
   logic [SAMPLE_W:0] trial;
   logic trial_ge;
   logic [SAMPLE_W-1:0] scaled;

   assign req_mux = req_tdata[2:0];
   assign req_sample = req_tdata[SAMPLE_W+2:3];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) calib_ff[i] <= CALIB_RESET[i];
      end else if (csr_we) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (csr_index == CSR_INDEX_W'(i)) calib_ff[i] <= csr_wdata;
         end
      end
   end

   // index decode and calibration lookup
   always_comb begin
      idx_in = SENSOR_IDX_W'(SENSOR_COUNT - 1) - req_mux;
      in_range_in = ({1'b0, idx_in} < (SENSOR_IDX_W + 1)'(SENSOR_COUNT));
      word = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (idx_in == SENSOR_IDX_W'(i)) word = calib_ff[i];
      end
      word_w = word[CALIB_W-1:SAMPLE_W];
      word_b = word[SAMPLE_W-1:0];
      if (word_b > word_w) begin
         w_in = word_b;
         b_in = word_w;
      end else begin
         w_in = word_w;
         b_in = word_b;
      end
   end

   // thresholds by reciprocal multiply, stretch numerator
   always_comb begin
      sum_u = {1'b0, w_ff, 1'b0} + (SAMPLE_W + 2)'(b_ff);
      sum_l = (SAMPLE_W + 2)'(w_ff) + {1'b0, b_ff, 1'b0};
      prod_u = 30'(sum_u) * 30'(RECIP3);
      prod_l = 30'(sum_l) * 30'(RECIP3);
      diff = s_ff - b_ff;
   end

   // one restoring division step
   always_comb begin
      trial = {rem_ff, num_lo_ff[SAMPLE_W-1]};
      trial_ge = (trial >= {1'b0, den_ff});
      rem_in = trial_ge ? SAMPLE_W'(trial - {1'b0, den_ff}) : trial[SAMPLE_W-1:0];
   end

   always_comb begin
      line_in = line_ff;
      if (in_range_ff) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (idx_ff == SENSOR_IDX_W'(i)) begin
               if (s_ff > upper_ff) line_in[i] = 1'b1;
               else if (s_ff < lower_ff) line_in[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (!in_range_ff || zero_ff) scaled = '0;
      else if (sat_ff) scaled = FULL_SCALE;
      else scaled = quot_ff;
      rsp_data_in = {1'b0, LINE_W'(line_ff), scaled, idx_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (cmd.update) begin
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= idx_in;
         in_range_ff <= in_range_in;
         s_ff <= req_sample;
         w_ff <= w_in;
         b_ff <= b_in;
      end
      if (cmd.thresh) begin
         upper_ff <= prod_u[SAMPLE_W+15:16];
         lower_ff <= prod_l[SAMPLE_W+15:16];
         // (s - b) * 4095 as (s - b) * 4096 - (s - b)
         num_ff <= {diff, {SAMPLE_W{1'b0}}} - CALIB_W'(diff);
         den_ff <= w_ff - b_ff;
         zero_ff <= (w_ff == b_ff) || (s_ff <= b_ff);
      end
      if (cmd.update) begin
         rem_ff <= num_ff[CALIB_W-1:SAMPLE_W];
         num_lo_ff <= num_ff[SAMPLE_W-1:0];
         quot_ff <= '0;
         // quotient overflows twelve bits when the top half reaches the divisor
         sat_ff <= (num_ff[CALIB_W-1:SAMPLE_W] >= den_ff);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         num_lo_ff <= {num_lo_ff[SAMPLE_W-2:0], 1'b0};
         quot_ff <= {quot_ff[SAMPLE_W-2:0], trial_ge};
      end
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/line_sensor_channel_conditioner_top.sv -----
// channel    direction   handshake                  payload
// req_       in          req_tvalid / req_tready    mux_select, sample
// rsp_       out         rsp_tvalid / rsp_tready    sensor_index, scaled_level, line_bits
// csr_       in          csr_we                     csr_index, csr_wdata
//
// one transaction steps through accept, threshold, line update, restoring division
// for the scaled level, then the output register load; a new request is accepted
// only after the last one's load. division yields one quotient bit per cycle.
// reset is synchronous; calibration returns to its defaults, line bits to zero.
// a result waits in the output register; a new transaction is taken meanwhile
// and only holds at its output load while the previous result is untaken.
`default_nettype none

module line_sensor_channel_conditioner_top #(
   parameter int SENSOR_COUNT = lscc_pkg::DEFAULT_SENSOR_COUNT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [2:0] mux_select, [14:3] sample, [15] unused
   input  wire  [lscc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [2:0] sensor_index, [14:3] scaled_level, [22:15] line_bits, [23] zero
   output logic [lscc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                               csr_we,
   input  wire  [lscc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [lscc_pkg::CALIB_W-1:0]      csr_wdata
);
   import lscc_pkg::*;

   lscc_cmd_type cmd;
   lscc_status_type status;

   lscc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lscc_datapath #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire
